// File: hw/rtl/vcu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcu_pkg
// Shared constants, codes and types of the vector clock unit.
// ----------------------------------------------------------------------------
package vcu_pkg;

	localparam int MAX_SITES  = 16;
	localparam int SITE_W     = 4;
	localparam int CNT_W      = 32;
	localparam int SUM_W      = CNT_W + SITE_W;
	localparam int FUNC_W     = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// item function codes
	localparam logic [FUNC_W-1:0] FN_LOCAL   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_MERGE   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_COMPARE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_READ    = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SITE_W-1:0] site;
		logic [CNT_W-1:0]  value;
		logic [SITE_W-1:0] other_site;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] own_count;
		logic [CNT_W-1:0] read_value;
		logic             less_or_equal;
		logic             general_smaller;
		logic             done_res;
	} result_t;

	typedef struct packed {
		logic              rd_en;
		logic [SITE_W-1:0] rd_addr_a;
		logic [SITE_W-1:0] rd_addr_b;
		logic              wr_en;
		logic [SITE_W-1:0] wr_addr;
		logic [CNT_W-1:0]  wr_data;
	} mem_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/vcu_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcu_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface vcu_in_if;
	logic                       valid;
	logic                       ready;
	logic [vcu_pkg::FUNC_W-1:0] func;
	logic [vcu_pkg::SITE_W-1:0] site;
	logic [vcu_pkg::CNT_W-1:0]  value;
	logic [vcu_pkg::SITE_W-1:0] other_site;
	logic                       last;

	modport source (output valid, func, site, value, other_site, last, input ready);
	modport sink   (input valid, func, site, value, other_site, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vcu_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcu_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface vcu_out_if;
	logic                      valid;
	logic                      ready;
	logic [vcu_pkg::CNT_W-1:0] own_count;
	logic [vcu_pkg::CNT_W-1:0] read_value;
	logic                      less_or_equal;
	logic                      general_smaller;
	logic                      done_res;

	modport source (output valid, own_count, read_value, less_or_equal, general_smaller,
		done_res, input ready);
	modport sink   (input valid, own_count, read_value, less_or_equal, general_smaller,
		done_res, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vector_clock_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector_clock_unit
// Vector clock with one saturating counter per site and a running sum.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch  : items (func, site, value, other_site, last); one transfer when
//           valid and ready are both high. func selects local event, merge
//           element, compare element or read of one entry.
//  out_ch : one result per item (own_count, read_value, less_or_equal,
//           general_smaller, done_res), in item order.
//  cfg    : cfg_wr_en/cfg_wr_data set own_site; write only while idle.
// Sequence: each item passes address/read, modify/write-back and hand-off
//  to the output register in turn; ready returns the cycle after the
//  hand-off, so a new item is taken only once the last one is handed off.
//  The owner bump of a merge's last element needs a second write to the
//  single-write-port store, which lands in the hand-off cycle.
// Reset: all counters read as zero (per-entry valid bits), sums cleared,
//  the compare flag set, own_site zero. No clearing pass is needed.
// Stall: a result waits in the output register; the next item is still
//  taken and processed, and it holds in its hand-off cycle until the
//  receiver takes the waiting result.
// ----------------------------------------------------------------------------
module vector_clock_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	vcu_in_if.sink                          in_ch,
	vcu_out_if.source                       out_ch,
	input  wire logic                       cfg_wr_en,
	input  wire logic [vcu_pkg::SITE_W-1:0] cfg_wr_data
);

	logic [vcu_pkg::SITE_W-1:0] own_site_q;
	vcu_pkg::item_t             item;
	logic                       item_take;
	logic                       item_ready;
	logic                       out_free;
	logic                       push;
	vcu_pkg::result_t           res;
	vcu_pkg::result_t           out_q;
	logic                       out_valid_q;
	vcu_pkg::mem_req_t          mem_req;
	logic [vcu_pkg::CNT_W-1:0]  rd_a;
	logic [vcu_pkg::CNT_W-1:0]  rd_b;

	// owner register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_site_q <= '0;
		end else if (cfg_wr_en) begin
			own_site_q <= cfg_wr_data;
		end
	end

	assign item.func       = in_ch.func;
	assign item.site       = in_ch.site;
	assign item.value      = in_ch.value;
	assign item.other_site = in_ch.other_site;
	assign item.last       = in_ch.last;
	assign in_ch.ready     = item_ready;
	assign item_take       = in_ch.valid && item_ready;

	vcu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.own_site   (own_site_q),
		.item       (item),
		.item_take  (item_take),
		.item_ready (item_ready),
		.out_free   (out_free),
		.push       (push),
		.res        (res),
		.mem_req    (mem_req),
		.rd_a       (rd_a),
		.rd_b       (rd_b)
	);

	vcu_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mem_req),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// output register: free when empty or being taken this cycle
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.own_count       = out_q.own_count;
	assign out_ch.read_value      = out_q.read_value;
	assign out_ch.less_or_equal   = out_q.less_or_equal;
	assign out_ch.general_smaller = out_q.general_smaller;
	assign out_ch.done_res        = out_q.done_res;

endmodule
`default_nettype wire

// File: hw/rtl/vcu_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcu_mem
// Counter store: one write port, two registered read ports, per-entry valid
// bits so that entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module vcu_mem (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire vcu_pkg::mem_req_t         req,
	output logic [vcu_pkg::CNT_W-1:0]      rd_data_a,
	output logic [vcu_pkg::CNT_W-1:0]      rd_data_b
);

	logic [vcu_pkg::CNT_W-1:0]     mem_q [vcu_pkg::MAX_SITES];
	logic [vcu_pkg::MAX_SITES-1:0] vld_q;
	logic [vcu_pkg::CNT_W-1:0]     rd_a_q;
	logic [vcu_pkg::CNT_W-1:0]     rd_b_q;
	logic                          va_q;
	logic                          vb_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_a_q <= mem_q[req.rd_addr_a];
			rd_b_q <= mem_q[req.rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				va_q <= vld_q[req.rd_addr_a];
				vb_q <= vld_q[req.rd_addr_b];
			end
		end
	end

	assign rd_data_a = va_q ? rd_a_q : '0;
	assign rd_data_b = vb_q ? rd_b_q : '0;

endmodule
`default_nettype wire

// File: hw/rtl/vcu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcu_ctrl
// Item sequencer: read both entries, update totals and flags, write back,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module vcu_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [vcu_pkg::SITE_W-1:0] own_site,
	input  wire vcu_pkg::item_t             item,
	input  wire logic                       item_take,
	output logic                            item_ready,
	input  wire logic                       out_free,
	output logic                            push,
	output vcu_pkg::result_t                res,
	output vcu_pkg::mem_req_t               mem_req,
	input  wire logic [vcu_pkg::CNT_W-1:0]  rd_a,
	input  wire logic [vcu_pkg::CNT_W-1:0]  rd_b
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]                state_q;
	vcu_pkg::item_t            item_q;
	vcu_pkg::result_t          res_q;
	logic [vcu_pkg::SUM_W-1:0] own_total_q;
	logic [vcu_pkg::SUM_W-1:0] other_total_q;
	logic                      le_run_q;
	logic                      bump_q;
	logic [vcu_pkg::CNT_W-1:0] own_next_q;

	// RD-state datapath (rd_a = entry at item site, rd_b = owner entry)
	logic                      is_local;
	logic                      is_merge;
	logic                      is_cmp;
	logic                      bump;
	logic                      raise;
	logic [vcu_pkg::CNT_W-1:0] own_inc;
	logic [vcu_pkg::CNT_W-1:0] diff;
	logic [vcu_pkg::SUM_W:0]   other_wide;
	logic [vcu_pkg::SUM_W-1:0] other_sum;
	logic                      le_next;
	logic                      gs;

	always_comb begin
		is_local   = item_q.func == vcu_pkg::FN_LOCAL;
		is_merge   = item_q.func == vcu_pkg::FN_MERGE;
		is_cmp     = item_q.func == vcu_pkg::FN_COMPARE;
		bump       = (is_local || (is_merge && item_q.last)) && (rd_b != vcu_pkg::CNT_MAX);
		raise      = is_merge && (item_q.site != own_site) && (item_q.value > rd_a);
		own_inc    = rd_b + vcu_pkg::CNT_W'(1);
		diff       = raise ? (item_q.value - rd_a) : '0;
		other_wide = {1'b0, other_total_q} + (vcu_pkg::SUM_W+1)'(item_q.value);
		other_sum  = other_wide[vcu_pkg::SUM_W] ? vcu_pkg::SUM_MAX
			: other_wide[vcu_pkg::SUM_W-1:0];
		le_next    = le_run_q && !(rd_a > item_q.value);
		gs         = (own_total_q < other_sum) ||
			((own_total_q == other_sum) && (own_site < item_q.other_site));
	end

	always_comb begin
		mem_req           = '0;
		mem_req.rd_en     = item_take;
		mem_req.rd_addr_a = item.site;
		mem_req.rd_addr_b = own_site;
		if (state_q == ST_RD && raise) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = item_q.site;
			mem_req.wr_data = item_q.value;
		end else if (state_q == ST_PUSH && bump_q) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = own_site;
			mem_req.wr_data = own_next_q;
		end
	end

	assign item_ready = state_q == ST_IDLE;
	assign push       = (state_q == ST_PUSH) && out_free;
	assign res        = res_q;

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_q <= item;
		end
		if (state_q == ST_RD) begin
			own_next_q            <= own_inc;
			res_q.own_count       <= bump ? own_inc : rd_b;
			res_q.read_value      <= (item_q.func == vcu_pkg::FN_READ) ? rd_a : '0;
			res_q.less_or_equal   <= is_cmp && item_q.last && le_next;
			res_q.general_smaller <= is_cmp && item_q.last && gs;
			res_q.done_res        <= (is_cmp || is_merge) && item_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			own_total_q   <= '0;
			other_total_q <= '0;
			le_run_q      <= 1'b1;
			bump_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q     <= ST_PUSH;
					bump_q      <= bump;
					own_total_q <= own_total_q + vcu_pkg::SUM_W'(diff)
						+ vcu_pkg::SUM_W'(bump);
					if (is_cmp) begin
						if (item_q.last) begin
							other_total_q <= '0;
							le_run_q      <= 1'b1;
						end else begin
							other_total_q <= other_sum;
							le_run_q      <= le_next;
						end
					end
				end
				ST_PUSH: begin
					bump_q <= 1'b0;
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
